// ===== src/neural_activation_unit_core_assert.svh =====
// assertion macros for the activation unit
`ifndef NEURAL_ACTIVATION_UNIT_CORE_ASSERT_SVH
`define NEURAL_ACTIVATION_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define NAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("activation unit assertion failed");
// condition that must never hold outside reset
`define NAU_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("activation unit forbidden condition");
`else
`define NAU_ASSERT(lbl, prop)
`define NAU_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== src/nau_pkg.sv =====
// shared types and constants of the activation unit
`timescale 1ns / 1ps
package nau_pkg;

  // default sigmoid table size
  localparam int unsigned SigTableDepthDef = 1024;

  // fixed field widths
  localparam int unsigned XW    = 16;
  localparam int unsigned YW    = 15;
  localparam int unsigned SW    = 9;
  localparam int unsigned FracW = 11;

  // 1.0 in q1.8
  localparam logic [SW-1:0] OneQ = 9'd256;

  // activation function codes
  typedef enum logic [1:0] {
    FnRelu  = 2'd0,
    FnDrelu = 2'd1,
    FnSigm  = 2'd2,
    FnDsigm = 2'd3
  } func_e;

  // per-beat control and side data carried down the pipe
  typedef struct packed {
    logic          valid;
    logic          last;
    func_e         func;
    logic          neg;
    logic          sat;
    logic [YW-1:0] relu;
  } stage_t;

endpackage

// ===== src/neural_activation_unit_core.sv =====
// top level of the element-wise activation unit
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | start_i (busy_o)     | x_in_i[15:0], last_in_i
//  result   | done_o strobe        | y_out_o[14:0], last_out_o
//  config   | cfg_we_i             | cfg_wdata_i[1:0]
//
// one beat accepted every cycle; busy_o is never raised
// each result is registered in turn by the index stage, table rom read, sign fold,
// and derivative multiply and select
// reset clears the valid bits and sets the function to relu
// the receiver takes every result; nothing in the pipe ever waits
`timescale 1ns / 1ps
`include "neural_activation_unit_core_assert.svh"
module neural_activation_unit_core
  import nau_pkg::*;
#(
  parameter int unsigned SigTableDepth = SigTableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [XW-1:0] x_in_i,
  input  logic          last_in_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,
  output logic          done_o,
  output logic [YW-1:0] y_out_o,
  output logic          last_out_o
);

  localparam int unsigned IdxW = $clog2(SigTableDepth);

  func_e           func_q;
  logic            accept;
  stage_t          s1;
  stage_t          s2;
  logic [IdxW-1:0] idx;
  logic [SW-1:0]   sig;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // function select register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= FnRelu;
    end else if (cfg_we_i) begin
      func_q <= func_e'(cfg_wdata_i);
    end
  end

  nau_index #(
    .SigTableDepth(SigTableDepth)
  ) u_index (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .x_i    (x_in_i),
    .last_i (last_in_i),
    .func_i (func_q),
    .stage_o(s1),
    .idx_o  (idx)
  );

  nau_sig_rom #(
    .SigTableDepth(SigTableDepth)
  ) u_rom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stage_i(s1),
    .idx_i  (idx),
    .stage_o(s2),
    .sig_o  (sig)
  );

  nau_post u_post (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stage_i(s2),
    .sig_i (sig),
    .done_o(done_o),
    .y_o   (y_out_o),
    .last_o(last_out_o)
  );

  // every beat yields exactly one result
  `NAU_ASSERT(a_beat_to_result, accept |-> ##4 done_o)
  // no result without an accepted beat before it
  `NAU_ASSERT(a_no_spurious, done_o |-> $past(accept, 4))
  // results of every function but relu never exceed 1.0
  `NAU_ASSERT(a_sig_bound, (accept && func_q != FnRelu) |-> ##4 (y_out_o <= YW'(OneQ)))
  // the end-of-matrix flag reaches the result of the same beat
  `NAU_ASSERT_NEVER(a_last_lost, done_o && ($past(last_in_i, 4) != last_out_o))

endmodule

// ===== src/nau_index.sv =====
// first stage: magnitude, range check and sigmoid table index
`timescale 1ns / 1ps
module nau_index
  import nau_pkg::*;
#(
  parameter int unsigned SigTableDepth = SigTableDepthDef,
  localparam int unsigned IdxW = $clog2(SigTableDepth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [XW-1:0]   x_i,
  input  logic            last_i,
  input  func_e           func_i,
  output stage_t          stage_o,
  output logic [IdxW-1:0] idx_o
);

  localparam int unsigned ProdW = FracW + $clog2(SigTableDepth + 1);

  logic [XW-1:0]    ax;
  logic             neg;
  logic [ProdW-1:0] scaled;
  stage_t           stage_d, stage_q;
  logic [IdxW-1:0]  idx_d, idx_q;

  // absolute value and bin index, lower edge of the bin
  always_comb begin
    neg     = x_i[XW-1];
    ax      = neg ? (~x_i + 1'b1) : x_i;
    scaled  = ProdW'(ax[FracW-1:0]) * ProdW'(SigTableDepth);
    idx_d   = IdxW'(scaled >> FracW);
    stage_d.valid = valid_i;
    stage_d.last  = last_i;
    stage_d.func  = func_i;
    stage_d.neg   = neg;
    stage_d.sat   = |ax[XW-1:FracW];
    stage_d.relu  = neg ? '0 : x_i[YW-1:0];
  end

  // stage register, valid bit cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      idx_q   <= '0;
    end else begin
      stage_q <= stage_d;
      idx_q   <= idx_d;
    end
  end

  assign stage_o = stage_q;
  assign idx_o   = idx_q;

endmodule

// ===== src/nau_sig_rom.sv =====
// second stage: sigmoid table rom with registered read
`timescale 1ns / 1ps
module nau_sig_rom
  import nau_pkg::*;
#(
  parameter int unsigned SigTableDepth = SigTableDepthDef,
  localparam int unsigned IdxW = $clog2(SigTableDepth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stage_t          stage_i,
  input  logic [IdxW-1:0] idx_i,
  output stage_t          stage_o,
  output logic [SW-1:0]   sig_o
);

  localparam int unsigned FixShift = 24;
  localparam int unsigned Terms    = 20;

  typedef logic [SW-1:0] tab_t [SigTableDepth];

  // shift and subtract quotient, used only while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid(8*i/depth) in q1.8 from a q24 series of e^(i/depth), squared three times
  function automatic tab_t build_table();
    tab_t        tab;
    logic [63:0] one;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] kk;
    logic [63:0] ent;
    one = 64'd1 << FixShift;
    for (int i = 0; i < SigTableDepth; i++) begin
      u    = udiv64(64'(i) << FixShift, 64'(SigTableDepth));
      term = one;
      sum  = one;
      for (int k = 1; k <= Terms; k++) begin
        kk   = 64'(k);
        term = udiv64((term * u) >> FixShift, kk);
        sum  = sum + term;
      end
      for (int k = 0; k < 3; k++) begin
        sum = (sum * sum) >> FixShift;
      end
      den    = sum + one;
      ent    = udiv64(64'd512 * sum + den, 64'd2 * den);
      tab[i] = SW'(ent);
    end
    return tab;
  endfunction

  localparam tab_t SigTab = build_table();

  stage_t        stage_q;
  logic [SW-1:0] sig_q;

  // side data, valid bit cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_i;
    end
  end

  // rom read
  always_ff @(posedge clk_i) begin
    sig_q <= SigTab[idx_i];
  end

  assign stage_o = stage_q;
  assign sig_o   = sig_q;

endmodule

// ===== src/nau_post.sv =====
// third and fourth stages: sign fold, saturation, derivative and result select
`timescale 1ns / 1ps
module nau_post
  import nau_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stage_t        stage_i,
  input  logic [SW-1:0] sig_i,
  output logic          done_o,
  output logic [YW-1:0] y_o,
  output logic          last_o
);

  stage_t            s3_q;
  logic [SW-1:0]     s_d, s_q;
  logic [SW-1:0]     comp;
  logic [2*SW-1:0]   prod;
  logic [2*SW-1:0]   dsig;
  logic [YW-1:0]     y_d, y_q;
  logic              done_q;
  logic              last_q;

  // fold negative side and saturate outside the table range
  always_comb begin
    if (stage_i.sat) begin
      s_d = stage_i.neg ? '0 : OneQ;
    end else begin
      s_d = stage_i.neg ? (OneQ - sig_i) : sig_i;
    end
  end

  // derivative product and function select
  always_comb begin
    comp = OneQ - s_q;
    prod = (2*SW)'(s_q) * (2*SW)'(comp);
    dsig = (prod + (2*SW)'(128)) >> 8;
    case (s3_q.func)
      FnRelu:  y_d = s3_q.relu;
      FnDrelu: y_d = s3_q.neg ? '0 : YW'(OneQ);
      FnSigm:  y_d = YW'(s_q);
      FnDsigm: y_d = YW'(dsig);
      default: y_d = '0;
    endcase
  end

  // side data and result strobe, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s3_q   <= stage_i;
      done_q <= s3_q.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    y_q    <= y_d;
    last_q <= s3_q.last;
  end

  assign done_o = done_q;
  assign y_o    = y_q;
  assign last_o = last_q;

endmodule

// ===== tb/sv/neural_activation_unit_core_test.sv =====
// self-checking testbench for the element-wise activation unit
`timescale 1ns / 1ps
module neural_activation_unit_core_test;
  import nau_pkg::*;

  localparam int unsigned SigDepth   = SigTableDepthDef;
  localparam int unsigned SatLimit   = 2048;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [XW-1:0] x;
    logic          last;
  } elem_t;

  typedef struct packed {
    logic [YW-1:0] y;
    logic          last;
  } act_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start_i     = 1'b0;
  logic [XW-1:0] x_in_i      = '0;
  logic          last_in_i   = 1'b0;
  logic          cfg_we_i    = 1'b0;
  logic [1:0]    cfg_wdata_i = 2'd0;
  logic          busy_o;
  logic          done_o;
  logic [YW-1:0] y_out_o;
  logic          last_out_o;

  // elements waiting to be driven, activations waiting to come out
  elem_t elem_queue[$];
  act_t  act_due[$];

  // sigmoid table and function register as the block should hold them
  logic [SW-1:0] sig_tab [SigDepth];
  func_e         fn_model = FnRelu;

  bit    gapless = 1'b0;
  elem_t next_elem;
  act_t  want;
  int    mismatches = 0;
  int    results_seen = 0;
  int    beats_by_fn [4] = '{0, 0, 0, 0};
  int    matrix_left = 0;

  neural_activation_unit_core #(
    .SigTableDepth(SigDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .x_in_i     (x_in_i),
    .last_in_i  (last_in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .y_out_o    (y_out_o),
    .last_out_o (last_out_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one table entry: e^t from a q24 taylor series and three squarings, then e^t/(e^t+1)
  function automatic logic [SW-1:0] sigmoid_entry(int unsigned i);
    longint unsigned one, u, term, sum, den;
    one  = 64'd1 << 24;
    u    = (longint'(i) << 24) / SigDepth;
    term = one;
    sum  = one;
    for (longint unsigned k = 1; k <= 20; k++) begin
      term = ((term * u) >> 24) / k;
      sum += term;
    end
    for (int k = 0; k < 3; k++) sum = (sum * sum) >> 24;
    den = sum + one;
    return SW'((2 * 256 * sum + den) / (2 * den));
  endfunction

  // expected activation of one element under function fn
  function automatic logic [YW-1:0] activation_of(func_e fn, logic [XW-1:0] x);
    int xs, ax, s;
    xs = int'($signed(x));
    ax = (xs < 0) ? -xs : xs;
    // sigmoid by table with odd symmetry, saturated at 8.0 and beyond
    if (ax >= SatLimit) s = (xs < 0) ? 0 : 256;
    else begin
      s = sig_tab[(ax * SigDepth) / SatLimit];
      if (xs < 0) s = 256 - s;
    end
    case (fn)
      FnRelu:  return (xs < 0) ? '0 : YW'(xs);
      FnDrelu: return (xs < 0) ? '0 : YW'(256);
      FnSigm:  return YW'(s);
      default: return YW'((s * (256 - s) + 128) >> 8);
    endcase
  endfunction

  // driver: present the next element, hold it while busy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      x_in_i    <= '0;
      last_in_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (elem_queue.size() != 0 && (gapless || $urandom_range(0, 99) >= 7)) begin
        next_elem = elem_queue.pop_front();
        start_i   <= 1'b1;
        x_in_i    <= next_elem.x;
        last_in_i <= next_elem.last;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predict each accepted beat, check each result strobe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        act_due.push_back('{y: activation_of(fn_model, x_in_i), last: last_in_i});
        beats_by_fn[fn_model]++;
      end
      if (done_o) begin
        results_seen++;
        if (act_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result: y %0d last %0b", y_out_o, last_out_o);
        end else begin
          want = act_due.pop_front();
          if (y_out_o !== want.y || last_out_o !== want.last) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch at result %0d: y exp %0d got %0d, last exp %0b got %0b",
                       results_seen, want.y, y_out_o, want.last, last_out_o);
          end
        end
      end
    end
  end

  task automatic push_elem(int v, bit last);
    elem_queue.push_back('{x: XW'(v), last: last});
  endtask

  // wait until every queued element is driven and every due result is checked
  task automatic drain_pipe();
    while (elem_queue.size() != 0 || start_i || act_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_function(func_e fn);
    drain_pipe();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fn;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fn_model = fn;
  endtask

  // random element: mostly the sigmoid range, plus full range and edges
  function automatic int rand_elem();
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, 65535));
      3, 4, 5, 6: return int'($urandom_range(0, 4095)) - 2048;
      7: return int'($urandom_range(0, 31)) - 16 + (($urandom_range(0, 1) != 0) ? 2048 : -2048);
      8: return int'($urandom_range(0, 7)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32767;
          1: return -32768;
          2: return -1;
          default: return 256;
        endcase
      end
    endcase
  endfunction

  // random beats grouped into matrices of random size
  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if (matrix_left == 0) matrix_left = $urandom_range(1, 24);
      matrix_left--;
      push_elem(rand_elem(), (matrix_left == 0) || ($urandom_range(0, 49) == 0));
    end
  endtask

  // stimulus and final verdict
  initial begin
    func_e phase_fn [8];
    phase_fn = '{FnDsigm, FnRelu, FnSigm, FnDrelu, FnSigm, FnDsigm, FnRelu, FnDrelu};
    for (int i = 0; i < SigDepth; i++) sig_tab[i] = sigmoid_entry(i);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // relu from reset: zero, extremes, sign edge
    push_elem(0, 1'b0);
    push_elem(32767, 1'b0);
    push_elem(-32768, 1'b0);
    push_elem(-1, 1'b0);
    push_elem(1, 1'b1);
    // relu derivative: zero counts as non-negative
    write_function(FnDrelu);
    push_elem(0, 1'b1);
    push_elem(-1, 1'b0);
    push_elem(-32768, 1'b0);
    push_elem(32767, 1'b1);
    // sigmoid: saturation edge, most negative input, bin edges
    write_function(FnSigm);
    push_elem(2047, 1'b0);
    push_elem(2048, 1'b0);
    push_elem(-2047, 1'b0);
    push_elem(-2048, 1'b0);
    push_elem(-32768, 1'b0);
    push_elem(0, 1'b0);
    push_elem(3, 1'b1);
    // sigmoid derivative: peak at zero, zero once saturated
    write_function(FnDsigm);
    push_elem(0, 1'b0);
    push_elem(2048, 1'b0);
    push_elem(-2049, 1'b0);
    push_elem(1, 1'b0);
    push_elem(-1, 1'b0);
    push_elem(32767, 1'b1);

    // random matrices under each function, one phase with no gaps
    for (int p = 0; p < 8; p++) begin
      write_function(phase_fn[p]);
      gapless = (p == 4);
      queue_random(100);
    end
    drain_pipe();
    mismatches += act_due.size();

    $display("checked %0d results over %0d function phases", results_seen, 12);
    $display("beats: relu %0d, relu deriv %0d, sigmoid %0d, sigmoid deriv %0d",
             beats_by_fn[0], beats_by_fn[1], beats_by_fn[2], beats_by_fn[3]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

  // run time limit
  initial begin
    #100000;
    $display("timeout");
    $display("Verification failed");
    $finish;
  end

endmodule
